// File: rtl/core/assert_macros.svh
// assertion macros used by the top level of the wildcard name matcher
// no dependencies; bodies drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: label");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: label");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// File: rtl/core/wnm_pkg.sv
// shared types and constants of the wildcard name matcher
// used by wnm_cfg, wnm_cell and wildcard_name_matcher
`timescale 1ns / 1ps
`default_nettype none

package wnm_pkg;

  localparam int PATTERN_CHARS_DEF = 16;
  localparam int REG_CHARS         = 16;
  localparam int LEN_BITS          = 5;
  localparam int CFG_INDEX_W       = 2;
  localparam int CFG_DATA_W        = 64;

  localparam logic [7:0] STAR_CHAR  = 8'h2A;
  localparam logic [7:0] QMARK_CHAR = 8'h3F;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CHARS_LOW  = 2'd0,
    CFG_CHARS_HIGH = 2'd1,
    CFG_LENGTH     = 2'd2
  } cfg_index_t;

  // handed from one cell to the next along the chain
  typedef struct packed {
    logic start;  // start vector bit for the receiving position
    logic carry;  // next-state bit arriving from the left neighbour
  } wnm_link_t;

endpackage

`default_nettype wire

// File: rtl/core/wildcard_name_matcher.sv
// top level of the wildcard name matcher: config block, row of cells, output register
// depends on wnm_pkg, wnm_cfg, wnm_cell and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

// Glob matcher for names streamed one byte per transaction. '*' matches any run of
// characters, '?' any single one, every other byte literally; the pattern is written
// through the cfg port while no name is in flight. Each byte gives one result: matched
// tells whether the name so far matches the whole pattern, tlast echoes the input tlast.
// One byte is accepted every clock while the output register is free or being taken; its
// result is registered there in the next cycle. The clock period is set by the ripple of
// the star closure through the row of cells, one cell per pattern character.
module wildcard_name_matcher
  import wnm_pkg::*;
#(
  parameter int PATTERN_CHARS = PATTERN_CHARS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,   // [7:0] name_byte
  input  wire logic                   s_axis_tlast,   // last_byte
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [7:0]                  m_axis_tdata,   // [0] matched, [7:1] zero
  output logic                        m_axis_tlast,   // end_of_name
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  `include "assert_macros.svh"

  localparam int CELLS = (PATTERN_CHARS < REG_CHARS) ? PATTERN_CHARS : REG_CHARS;
  localparam int LEN_W = $clog2(CELLS + 1);

  logic [7:0]       pat_chars [CELLS];
  logic [LEN_W-1:0] len_eff;
  logic             restart_req;
  logic             restart;
  logic             accept;
  wnm_link_t        links [CELLS+1];
  logic [CELLS:0]   closed_vec;
  logic             matched_reg;

  wnm_cfg #(
    .PATTERN_CHARS(PATTERN_CHARS)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pat_chars  (pat_chars),
    .len_eff    (len_eff),
    .restart_req(restart_req)
  );

  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;

  assign links[0] = '{start: 1'b1, carry: 1'b0};

  for (genvar p = 0; p < CELLS; p++) begin : g_cell
    wnm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (accept),
      .restart  (restart),
      .in_use   (len_eff > LEN_W'(p)),
      .pat_char (pat_chars[p]),
      .name_byte(s_axis_tdata),
      .link_in  (links[p]),
      .link_out (links[p+1]),
      .closed   (closed_vec[p])
    );
  end

  // the position past the last cell only ever receives from its left
  assign closed_vec[CELLS] = links[CELLS].carry;

  // start vector applies after reset, a pattern write or the last byte of a name
  always_ff @(posedge clk) begin
    if (rst) begin
      restart <= 1'b1;
    end else if (restart_req) begin
      restart <= 1'b1;
    end else if (accept) begin
      restart <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      matched_reg  <= closed_vec[len_eff];
      m_axis_tlast <= s_axis_tlast;
    end
  end

  assign m_axis_tdata = {7'd0, matched_reg};

  `ASSERT_PROP(a_cfg_restart, clk, rst, restart_req |=> restart)
  `ASSERT_PROP(a_last_restart, clk, rst, (accept && s_axis_tlast && !restart_req) |=> restart)
  `ASSERT_PROP(a_last_out, clk, rst, (accept && s_axis_tlast) |=> (m_axis_tvalid && m_axis_tlast))
  `ASSERT_NEVER(a_empty_no_match, clk, rst, m_axis_tvalid && matched_reg && (len_eff == '0))

endmodule

`default_nettype wire

// File: rtl/core/wnm_cfg.sv
// pattern registers and the write decode of the configuration port
// depends on wnm_pkg
`timescale 1ns / 1ps
`default_nettype none

module wnm_cfg
  import wnm_pkg::*;
#(
  parameter int PATTERN_CHARS = PATTERN_CHARS_DEF,
  parameter int CELLS         = (PATTERN_CHARS < REG_CHARS) ? PATTERN_CHARS : REG_CHARS,
  parameter int LEN_W         = $clog2(CELLS + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output logic [7:0]                  pat_chars [CELLS],
  output logic [LEN_W-1:0]            len_eff,
  output logic                        restart_req
);

  logic [CFG_DATA_W-1:0] chars_low;
  logic [CFG_DATA_W-1:0] chars_high;
  logic [LEN_BITS-1:0]   len_reg;
  logic                  hit_reg;

  always_comb begin
    hit_reg = 1'b0;
    unique case (cfg_index_t'(cfg_index))
      CFG_CHARS_LOW, CFG_CHARS_HIGH, CFG_LENGTH: hit_reg = 1'b1;
      default: hit_reg = 1'b0;
    endcase
  end

  assign restart_req = cfg_we & hit_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      chars_low  <= '0;
      chars_high <= '0;
      len_reg    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_CHARS_LOW:  chars_low  <= cfg_data;
        CFG_CHARS_HIGH: chars_high <= cfg_data;
        CFG_LENGTH:     len_reg    <= cfg_data[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // saturate to the number of cells
  assign len_eff = (len_reg > LEN_BITS'(CELLS)) ? LEN_W'(CELLS) : LEN_W'(len_reg);

  for (genvar i = 0; i < CELLS; i++) begin : g_chars
    if (i < 8) begin : g_low
      assign pat_chars[i] = chars_low[8*i +: 8];
    end else begin : g_high
      assign pat_chars[i] = chars_high[8*(i-8) +: 8];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/wnm_cell.sv
// one pattern position of the matcher: its active bit and its step logic
// depends on wnm_pkg
`timescale 1ns / 1ps
`default_nettype none

module wnm_cell
  import wnm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       advance,
  input  wire logic       restart,
  input  wire logic       in_use,
  input  wire logic [7:0] pat_char,
  input  wire logic [7:0] name_byte,
  input  wire wnm_link_t  link_in,
  output wnm_link_t       link_out,
  output logic            closed
);

  logic active;
  logic cur;
  logic live;
  logic is_star;
  logic hit;
  logic consumed;

  // after reset, a write or the end of a name the start vector stands in
  assign cur      = restart ? link_in.start : active;
  assign is_star  = (pat_char == STAR_CHAR);
  assign hit      = (pat_char == QMARK_CHAR) || (pat_char == name_byte);
  assign live     = cur & in_use;
  assign consumed = live & ~is_star & hit;

  // a star keeps its own position and passes the closure on
  assign closed         = (live & is_star) | link_in.carry;
  assign link_out.start = link_in.start & is_star & in_use;
  assign link_out.carry = consumed | (closed & is_star & in_use);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (advance) begin
      active <= closed;
    end
  end

endmodule

`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench for the wildcard name matcher: streams names against glob patterns
// depends on wnm_pkg and wildcard_name_matcher; predicts every verdict in its own automaton
`timescale 1ns / 1ps

module testbench;
  import wnm_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 130;

  typedef struct packed {
    logic matched;
    logic end_of_name;
  } name_verdict_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  wire                    s_axis_tready;
  logic [7:0]             s_axis_tdata = 8'd0;   // [7:0] name_byte
  logic                   s_axis_tlast = 1'b0;   // last_byte
  wire                    m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  wire  [7:0]             m_axis_tdata;          // [0] matched, [7:1] zero
  wire                    m_axis_tlast;          // end_of_name
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor state
  logic [63:0] chars_low_q;
  logic [63:0] chars_high_q;
  logic [4:0]  length_q;
  logic [16:0] active_q;

  name_verdict_t verdicts_due[$];
  logic [7:0]    name_bytes[$];
  logic [7:0]    pattern_bytes[16];
  int            error_count = 0;
  int            idle_cycles = 0;

  // stimulus shaping
  logic     tx_bursty = 1'b0;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_ALWAYS;
  logic     hold_request = 1'b0;
  int       hold_left = 0;
  int       rx_cycle = 0;

  wildcard_name_matcher i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned effective_length();
    int unsigned lim;
    lim = (PATTERN_CHARS_DEF < REG_CHARS) ? PATTERN_CHARS_DEF : REG_CHARS;
    return (length_q > lim) ? lim : length_q;
  endfunction

  function automatic logic [7:0] char_at(int unsigned i);
    if (i < 8) return chars_low_q[8*i +: 8];
    if (i < 16) return chars_high_q[8*(i-8) +: 8];
    return 8'd0;
  endfunction

  // one upward sweep is enough, a star can only enable the position after it
  function automatic logic [16:0] close_over_stars(logic [16:0] v);
    int unsigned n;
    n = effective_length();
    for (int unsigned p = 0; p < n; p++) begin
      if (v[p] && char_at(p) == STAR_CHAR) v[p+1] = 1'b1;
    end
    return v;
  endfunction

  function automatic logic [16:0] start_positions();
    return close_over_stars(17'd1);
  endfunction

  function automatic name_verdict_t match_next_byte(logic [7:0] c, logic last);
    int unsigned   n;
    logic [16:0]   nxt;
    logic [7:0]    pc;
    name_verdict_t r;
    n = effective_length();
    nxt = '0;
    for (int unsigned p = 0; p < n; p++) begin
      if (active_q[p]) begin
        pc = char_at(p);
        if (pc == STAR_CHAR) nxt[p] = 1'b1;
        else if (pc == QMARK_CHAR || pc == c) nxt[p+1] = 1'b1;
      end
    end
    nxt = close_over_stars(nxt);
    r.matched = nxt[n];
    r.end_of_name = last;
    active_q = last ? start_positions() : nxt;
    return r;
  endfunction

  initial begin
    chars_low_q = '0;
    chars_high_q = '0;
    length_q = '0;
    active_q = start_positions();
  end

  // ---------------------------------------------------------------- monitor and checker

  always @(posedge clk) begin : monitor
    name_verdict_t want;
    name_verdict_t due;
    logic          busy;
    busy = 1'b0;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        due = match_next_byte(s_axis_tdata, s_axis_tlast);
        verdicts_due.insert(verdicts_due.size(), due);
        busy = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        busy = 1'b1;
        if (verdicts_due.size() == 0) begin
          $error("result transaction with nothing expected: matched %0b end_of_name %0b",
                 m_axis_tdata[0], m_axis_tlast);
          error_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (m_axis_tdata[0] !== want.matched) begin
            $error("matched: expected %0b, got %0b", want.matched, m_axis_tdata[0]);
            error_count++;
          end
          if (m_axis_tlast !== want.end_of_name) begin
            $error("end_of_name: expected %0b, got %0b", want.end_of_name, m_axis_tlast);
            error_count++;
          end
          if (m_axis_tdata[7:1] !== 7'd0) begin
            $error("tdata padding: expected %0h, got %0h", 7'd0, m_axis_tdata[7:1]);
            error_count++;
          end
        end
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin : receiver
    rx_cycle++;
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:   m_axis_tready <= 1'b1;
        RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 9) < 7);
        RX_PERIODIC: m_axis_tready <= ((rx_cycle % 7) < 4);
        default:     m_axis_tready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_name_byte(input logic [7:0] b, input logic last);
    int gap;
    if (tx_bursty) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, 6);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_name();
    foreach (name_bytes[i]) send_name_byte(name_bytes[i], i == name_bytes.size() - 1);
  endtask

  // stop offering and wait for every outstanding verdict
  task automatic wait_for_verdicts();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CHARS_LOW) chars_low_q = data;
    else if (idx == CFG_CHARS_HIGH) chars_high_q = data;
    else if (idx == CFG_LENGTH) length_q = data[4:0];
    if (idx != CFG_UNUSED) active_q = start_positions();
    @(posedge clk);
  endtask

  task automatic program_pattern(input logic [4:0] len);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] lw;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = pattern_bytes[i];
      hi[8*i +: 8] = pattern_bytes[i+8];
    end
    // upper bits of the length word must be ignored
    lw = {$urandom(), $urandom()};
    lw[4:0] = len;
    write_register(CFG_CHARS_LOW, lo);
    write_register(CFG_CHARS_HIGH, hi);
    write_register(CFG_LENGTH, lw);
  endtask

  // unused pattern slots get random filler
  task automatic set_pattern(input string s);
    for (int i = 0; i < 16; i++)
      pattern_bytes[i] = (i < s.len()) ? s[i] : 8'($urandom_range(0, 255));
  endtask

  function automatic void add_name_byte(logic [7:0] b);
    name_bytes.insert(name_bytes.size(), b);
  endfunction

  task automatic set_name(input string s);
    name_bytes.delete();
    for (int i = 0; i < s.len(); i++) add_name_byte(s[i]);
  endtask

  function automatic logic [7:0] name_char();
    if ($urandom_range(0, 4) != 0) return 8'h61 + 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly names that follow the pattern, some bent out of shape
  task automatic build_name(input logic noise);
    int unsigned n;
    int          k;
    n = effective_length();
    name_bytes.delete();
    if (noise || n == 0) begin
      repeat ($urandom_range(1, 12)) add_name_byte(name_char());
    end else begin
      for (int unsigned i = 0; i < n; i++) begin
        if (pattern_bytes[i] == STAR_CHAR) begin
          repeat ($urandom_range(0, 3)) add_name_byte(name_char());
        end else if (pattern_bytes[i] == QMARK_CHAR) begin
          add_name_byte(8'($urandom_range(0, 255)));
        end else begin
          add_name_byte(pattern_bytes[i]);
        end
      end
      if ($urandom_range(0, 9) < 3 && name_bytes.size() != 0) begin
        k = $urandom_range(0, name_bytes.size() - 1);
        case ($urandom_range(0, 2))
          0:       name_bytes[k] = name_char();
          1:       name_bytes.delete(k);
          default: add_name_byte(name_char());
        endcase
      end
      if (name_bytes.size() == 0) add_name_byte(name_char());
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_empty_pattern();
    set_name("a");
    send_name();
    name_bytes = '{8'h00};
    send_name();
    wait_for_verdicts();
  endtask

  task automatic test_literal_extremes();
    pattern_bytes[0] = 8'h00;
    pattern_bytes[1] = 8'hFF;
    pattern_bytes[2] = 8'h61;
    program_pattern(5'd3);
    name_bytes = '{8'h00, 8'hFF, 8'h61};
    send_name();
    name_bytes = '{8'h00, 8'hFE};
    send_name();
    wait_for_verdicts();
  endtask

  task automatic test_wildcards();
    set_pattern("*?b*");
    program_pattern(5'd4);
    set_name("xb");
    send_name();
    set_name("b");
    send_name();
    set_name("abbz");
    send_name();
    wait_for_verdicts();
  endtask

  task automatic test_length_saturation();
    set_pattern("***************z");
    program_pattern(5'd31);
    set_name("z");
    send_name();
    set_name("y");
    send_name();
    wait_for_verdicts();
    write_register(CFG_LENGTH, 64'd17);
    set_name("z");
    send_name();
    wait_for_verdicts();
  endtask

  task automatic test_writes_mid_name();
    set_pattern("ab");
    program_pattern(5'd2);
    // unused index must not restart the name in progress
    name_bytes = '{8'h61};
    name_bytes[0] = 8'h61;
    send_name_byte(8'h61, 1'b0);
    wait_for_verdicts();
    write_register(CFG_UNUSED, {$urandom(), $urandom()});
    send_name_byte(8'h62, 1'b1);
    // a real register write does restart it
    send_name_byte(8'h61, 1'b0);
    wait_for_verdicts();
    write_register(CFG_LENGTH, 64'd2);
    send_name_byte(8'h62, 1'b1);
    wait_for_verdicts();
  endtask

  task automatic test_random_patterns();
    int          sent;
    int unsigned chars;
    int unsigned r;
    logic [4:0]  len;
    for (int phase = 0; phase < 11; phase++) begin
      tx_bursty = (phase % 3 != 0);
      rx_mode = (phase == 0) ? RX_ALWAYS : rx_mode_t'($urandom_range(0, 3));
      chars = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      for (int i = 0; i < 16; i++) begin
        r = $urandom_range(0, 19);
        if (phase == 5) pattern_bytes[i] = 8'($urandom_range(0, 255));
        else if (r < 5) pattern_bytes[i] = STAR_CHAR;
        else if (r < 8) pattern_bytes[i] = QMARK_CHAR;
        else if (r < 18) pattern_bytes[i] = 8'h61 + 8'($urandom_range(0, 2));
        else pattern_bytes[i] = 8'($urandom_range(0, 255));
      end
      r = $urandom_range(0, 24);
      if (phase == 5) len = 5'd16;
      else if (r < 2) len = 5'd0;
      else if (r < 5) len = 5'($urandom_range(17, 31));
      else len = 5'(chars);
      program_pattern(len);
      if ($urandom_range(0, 4) == 0) write_register(CFG_UNUSED, {$urandom(), $urandom()});
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_name($urandom_range(0, 3) == 0);
        send_name();
        sent += name_bytes.size();
      end
      wait_for_verdicts();
    end
  endtask

  // receiver stops for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    int sent;
    tx_bursty = 1'b0;
    rx_mode = RX_ALWAYS;
    set_pattern("a*?b");
    program_pattern(5'd4);
    hold_request = 1'b1;
    sent = 0;
    while (sent < 100) begin
      build_name($urandom_range(0, 3) == 0);
      send_name();
      sent += name_bytes.size();
    end
    wait_for_verdicts();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_pattern();
    test_literal_extremes();
    test_wildcards();
    test_length_saturation();
    test_writes_mid_name();
    test_random_patterns();
    test_backpressure();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/wnm_pkg.sv
rtl/core/wnm_cfg.sv
rtl/core/wnm_cell.sv
rtl/core/wildcard_name_matcher.sv
tb/testbench.sv
